// File: rtl/brainfuck_instruction_executor_core_assert.svh
// assertion helpers used by the checker file
`ifndef BRAINFUCK_INSTRUCTION_EXECUTOR_CORE_ASSERT_SVH
`define BRAINFUCK_INSTRUCTION_EXECUTOR_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define BFIE_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define BFIE_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bfie_pkg.sv
package bfie_pkg;

  // default store sizes
  localparam int unsigned CodeDepthDef = 4096;
  localparam int unsigned DataDepthDef = 32768;

  // payload and register widths
  localparam int unsigned ModeW     = 2;
  localparam int unsigned CodeAddrW = 12;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned PcOutW    = 13;
  localparam int unsigned ReasonW   = 2;
  localparam int unsigned CodeLenW  = 13;
  localparam int unsigned MemLimW   = 16;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [CodeLenW-1:0] CodeLenRst = 13'd1;
  localparam logic [MemLimW-1:0]  MemLimRst  = 16'd30000;

  // halt flag bits
  localparam int unsigned FlagW   = 3;
  localparam int unsigned FlagEnd = 0;
  localparam int unsigned FlagPtr = 1;
  localparam int unsigned FlagBrk = 2;

  // command characters
  localparam logic [ByteW-1:0] OpRight = 8'h3E;
  localparam logic [ByteW-1:0] OpLeft  = 8'h3C;
  localparam logic [ByteW-1:0] OpOut   = 8'h2E;
  localparam logic [ByteW-1:0] OpIn    = 8'h2C;
  localparam logic [ByteW-1:0] OpInc   = 8'h2B;
  localparam logic [ByteW-1:0] OpDec   = 8'h2D;
  localparam logic [ByteW-1:0] OpJmpF  = 8'h5B;
  localparam logic [ByteW-1:0] OpJmpB  = 8'h5D;

  typedef enum logic [ModeW-1:0] {
    ModeLoad    = 2'd0,
    ModeRestart = 2'd1,
    ModeStep    = 2'd2
  } mode_e;

  typedef enum logic [ReasonW-1:0] {
    ReasonRun = 2'd0,
    ReasonEnd = 2'd1,
    ReasonPtr = 2'd2,
    ReasonBrk = 2'd3
  } reason_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCodeLen  = 1'b0,
    CfgMemLimit = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StScanAdv,
    StScanCmp,
    StDone
  } state_e;

  typedef struct packed {
    logic re;
    logic we;
  } mem_ctl_t;

endpackage

// File: rtl/bfie_if.sv
interface bfie_in_if;
  import bfie_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ModeW-1:0]     mode;
  logic [CodeAddrW-1:0] code_addr;
  logic [ByteW-1:0]     code_byte;
  logic [ByteW-1:0]     in_byte;

  modport source (output valid, mode, code_addr, code_byte, in_byte, input ready);
  modport sink   (input valid, mode, code_addr, code_byte, in_byte, output ready);
endinterface

interface bfie_out_if;
  import bfie_pkg::*;

  logic               valid;
  logic               ready;
  logic               out_valid;
  logic [ByteW-1:0]   out_byte;
  logic               took_input;
  logic               halted;
  logic [ReasonW-1:0] halt_reason;
  logic [PcOutW-1:0]  pc_value;

  modport source (output valid, out_valid, out_byte, took_input, halted, halt_reason,
                  pc_value, input ready);
  modport sink   (input valid, out_valid, out_byte, took_input, halted, halt_reason,
                  pc_value, output ready);
endinterface

// File: rtl/brainfuck_instruction_executor_core.sv
// one item at a time; load, restart and halted steps go from idle straight to the done state,
// which loads the result register; plain commands read code and cell together, then write the cell back
// a taken bracket then passes an advance and a compare state per code byte scanned (one code store read per byte)
// after reset a sweep zeroes the data store, no item taken until done
// reset clears pc, pointer, halt flags, the result valid and config (length 1, limit 30000)
module brainfuck_instruction_executor_core #(
  parameter int unsigned CODE_DEPTH = bfie_pkg::CodeDepthDef,
  parameter int unsigned DATA_DEPTH = bfie_pkg::DataDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bfie_in_if.sink                       in_ch,
  bfie_out_if.source                    out_ch,
  input  logic                          cfg_we_i,
  input  logic [bfie_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bfie_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import bfie_pkg::*;

  localparam int unsigned CA_W  = $clog2(CODE_DEPTH);
  localparam int unsigned PC_W  = $clog2(CODE_DEPTH + 1);
  localparam int unsigned DA_W  = $clog2(DATA_DEPTH);
  localparam int unsigned LIM_W = $clog2(DATA_DEPTH + 1);

  // config registers
  logic [CodeLenW-1:0] code_len_q;
  logic [MemLimW-1:0]  mem_lim_q;
  logic [PC_W-1:0]     eff_len;
  logic [LIM_W-1:0]    eff_lim;

  // machine state
  state_e           state_q, state_d;
  logic [PC_W-1:0]  pc_q, pc_d;
  logic [DA_W-1:0]  ptr_q, ptr_d;
  logic [FlagW-1:0] flags_q, flags_d;
  logic [PC_W-1:0]  depth_q, depth_d;
  logic             fwd_q, fwd_d;
  logic [ByteW-1:0] in_byte_q, in_byte_d;

  // per-item result staging
  logic             res_ov_q, res_ov_d;
  logic [ByteW-1:0] res_ob_q, res_ob_d;
  logic             res_ti_q, res_ti_d;

  // output register
  logic               out_vld_q, out_vld_d;
  logic               out_ov_q, out_ov_d;
  logic [ByteW-1:0]   out_ob_q, out_ob_d;
  logic               out_ti_q, out_ti_d;
  logic               out_halt_q, out_halt_d;
  logic [ReasonW-1:0] out_reason_q, out_reason_d;
  logic [PcOutW-1:0]  out_pc_q, out_pc_d;

  // memory hookup
  mem_ctl_t         code_ctl, data_ctl;
  logic [CA_W-1:0]  code_raddr, code_waddr;
  logic [ByteW-1:0] code_rdata;
  logic [ByteW-1:0] data_wdata, data_rdata;
  logic             clr_busy;

  // control decode
  logic             accept;
  logic             out_free;
  logic             step_go;
  logic             jump_take;
  logic             scan_stop;
  logic [PC_W-1:0]  pc_inc, pc_dec;
  logic [LIM_W-1:0] ptr_inc_lim;
  logic [ByteW-1:0] op_same, op_other;
  logic [PC_W-1:0]  depth_nxt;
  reason_e          reason;

  bfie_code_mem #(
    .DEPTH (CODE_DEPTH)
  ) u_code_mem (
    .clk_i   (clk_i),
    .ctl_i   (code_ctl),
    .raddr_i (code_raddr),
    .waddr_i (code_waddr),
    .wdata_i (in_ch.code_byte),
    .rdata_o (code_rdata)
  );

  bfie_data_mem #(
    .DEPTH (DATA_DEPTH)
  ) u_data_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (data_ctl),
    .addr_i  (ptr_q),
    .wdata_i (data_wdata),
    .rdata_o (data_rdata),
    .busy_o  (clr_busy)
  );

  // config writes must arrive only while idle; the block itself does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_len_q <= CodeLenRst;
      mem_lim_q  <= MemLimRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgCodeLen:  code_len_q <= cfg_wdata_i[CodeLenW-1:0];
        CfgMemLimit: mem_lim_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // code length clamped to the store, limit clamped to the store and to at least one
  always_comb begin
    if (32'(code_len_q) > CODE_DEPTH) begin
      eff_len = PC_W'(CODE_DEPTH);
    end else begin
      eff_len = PC_W'(code_len_q);
    end
    if (32'(mem_lim_q) > DATA_DEPTH) begin
      eff_lim = LIM_W'(DATA_DEPTH);
    end else if (mem_lim_q == '0) begin
      eff_lim = LIM_W'(1);
    end else begin
      eff_lim = LIM_W'(mem_lim_q);
    end
  end

  // handshake: ready only when idle and the data store is cleared
  assign in_ch.ready = (state_q == StIdle) && !clr_busy;
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_vld_q || out_ch.ready;

  assign pc_inc      = pc_q + PC_W'(1);
  assign pc_dec      = pc_q - PC_W'(1);
  assign ptr_inc_lim = LIM_W'(ptr_q) + LIM_W'(1);

  // a step runs only inside the code and with no flag set
  assign step_go = (in_ch.mode == ModeStep) && (pc_q < eff_len) && (flags_q == '0);

  // brackets: '[' jumps on a zero cell, ']' jumps back on a non-zero cell
  assign jump_take = ((code_rdata == OpJmpF) && (data_rdata == '0)) ||
                     ((code_rdata == OpJmpB) && (data_rdata != '0));

  // scan runs off the code at either end
  assign scan_stop = fwd_q ? (pc_inc >= eff_len) : (pc_q == '0);

  assign op_same  = fwd_q ? OpJmpF : OpJmpB;
  assign op_other = fwd_q ? OpJmpB : OpJmpF;

  // nesting depth after the byte just read
  always_comb begin
    depth_nxt = depth_q;
    if (code_rdata == op_same) begin
      depth_nxt = depth_q + PC_W'(1);
    end else if (code_rdata == op_other) begin
      depth_nxt = depth_q - PC_W'(1);
    end
  end

  // reported reason: bracket over pointer over end
  always_comb begin
    if (flags_q[FlagBrk]) begin
      reason = ReasonBrk;
    end else if (flags_q[FlagPtr]) begin
      reason = ReasonPtr;
    end else if (flags_q[FlagEnd]) begin
      reason = ReasonEnd;
    end else begin
      reason = ReasonRun;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = step_go ? StExec : StDone;
        end
      end
      StExec: begin
        state_d = jump_take ? StScanAdv : StDone;
      end
      StScanAdv: begin
        state_d = scan_stop ? StDone : StScanCmp;
      end
      StScanCmp: begin
        state_d = (depth_nxt == '0) ? StDone : StScanAdv;
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    pc_d       = pc_q;
    ptr_d      = ptr_q;
    flags_d    = flags_q;
    depth_d    = depth_q;
    fwd_d      = fwd_q;
    in_byte_d  = in_byte_q;
    res_ov_d   = res_ov_q;
    res_ob_d   = res_ob_q;
    res_ti_d   = res_ti_q;
    code_ctl   = '0;
    data_ctl   = '0;
    code_raddr = pc_q[CA_W-1:0];
    code_waddr = CA_W'(in_ch.code_addr);
    data_wdata = in_byte_q;

    out_vld_d    = out_vld_q && !out_ch.ready;
    out_ov_d     = out_ov_q;
    out_ob_d     = out_ob_q;
    out_ti_d     = out_ti_q;
    out_halt_d   = out_halt_q;
    out_reason_d = out_reason_q;
    out_pc_d     = out_pc_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          res_ov_d  = 1'b0;
          res_ob_d  = '0;
          res_ti_d  = 1'b0;
          in_byte_d = in_ch.in_byte;
          case (in_ch.mode)
            ModeLoad: begin
              // loads beyond the store are dropped
              code_ctl.we = (32'(in_ch.code_addr) < CODE_DEPTH);
            end
            ModeRestart: begin
              pc_d    = '0;
              ptr_d   = '0;
              flags_d = '0;
            end
            ModeStep: begin
              // end flag may join an earlier flag
              if (pc_q >= eff_len) begin
                flags_d[FlagEnd] = 1'b1;
              end
              // fetch the command and the current cell together
              code_ctl.re = step_go;
              data_ctl.re = step_go;
            end
            default: ;
          endcase
        end
      end
      StExec: begin
        pc_d = pc_inc;
        unique case (code_rdata)
          OpRight: begin
            if (ptr_inc_lim >= eff_lim) begin
              flags_d[FlagPtr] = 1'b1;
            end else begin
              ptr_d = ptr_q + DA_W'(1);
            end
          end
          OpLeft: begin
            if (ptr_q == '0) begin
              flags_d[FlagPtr] = 1'b1;
            end else begin
              ptr_d = ptr_q - DA_W'(1);
            end
          end
          OpOut: begin
            res_ov_d = 1'b1;
            res_ob_d = data_rdata;
          end
          OpIn: begin
            data_ctl.we = 1'b1;
            data_wdata  = in_byte_q;
            res_ti_d    = 1'b1;
          end
          OpInc: begin
            data_ctl.we = 1'b1;
            data_wdata  = data_rdata + ByteW'(1);
          end
          OpDec: begin
            data_ctl.we = 1'b1;
            data_wdata  = data_rdata - ByteW'(1);
          end
          OpJmpF, OpJmpB: begin
            if (jump_take) begin
              // pc stays at the bracket here; the scan then walks it byte by byte
              pc_d    = pc_q;
              depth_d = PC_W'(1);
              fwd_d   = (code_rdata == OpJmpF);
            end
          end
          default: ;
        endcase
      end
      StScanAdv: begin
        if (scan_stop) begin
          flags_d[FlagBrk] = 1'b1;
        end else begin
          pc_d        = fwd_q ? pc_inc : pc_dec;
          code_raddr  = fwd_q ? pc_inc[CA_W-1:0] : pc_dec[CA_W-1:0];
          code_ctl.re = 1'b1;
        end
      end
      StScanCmp: begin
        depth_d = depth_nxt;
        // matching bracket found: step past it
        if (depth_nxt == '0) begin
          pc_d = pc_inc;
        end
      end
      StDone: begin
        if (out_free) begin
          out_vld_d    = 1'b1;
          out_ov_d     = res_ov_q;
          out_ob_d     = res_ob_q;
          out_ti_d     = res_ti_q;
          out_halt_d   = (flags_q != '0);
          out_reason_d = reason;
          out_pc_d     = PcOutW'(pc_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      pc_q      <= '0;
      ptr_q     <= '0;
      flags_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pc_q      <= pc_d;
      ptr_q     <= ptr_d;
      flags_q   <= flags_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    depth_q      <= depth_d;
    fwd_q        <= fwd_d;
    in_byte_q    <= in_byte_d;
    res_ov_q     <= res_ov_d;
    res_ob_q     <= res_ob_d;
    res_ti_q     <= res_ti_d;
    out_ov_q     <= out_ov_d;
    out_ob_q     <= out_ob_d;
    out_ti_q     <= out_ti_d;
    out_halt_q   <= out_halt_d;
    out_reason_q <= out_reason_d;
    out_pc_q     <= out_pc_d;
  end

  assign out_ch.valid       = out_vld_q;
  assign out_ch.out_valid   = out_ov_q;
  assign out_ch.out_byte    = out_ob_q;
  assign out_ch.took_input  = out_ti_q;
  assign out_ch.halted      = out_halt_q;
  assign out_ch.halt_reason = out_reason_q;
  assign out_ch.pc_value    = out_pc_q;
endmodule

// File: rtl/bfie_code_mem.sv
module bfie_code_mem #(
  parameter int unsigned DEPTH = bfie_pkg::CodeDepthDef,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                     clk_i,
  input  bfie_pkg::mem_ctl_t       ctl_i,
  input  logic [AW-1:0]            raddr_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [bfie_pkg::ByteW-1:0] wdata_i,
  output logic [bfie_pkg::ByteW-1:0] rdata_o
);
  import bfie_pkg::*;

  logic [ByteW-1:0] mem [DEPTH];
  logic [ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[waddr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// File: rtl/bfie_data_mem.sv
module bfie_data_mem #(
  parameter int unsigned DEPTH = bfie_pkg::DataDepthDef,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bfie_pkg::mem_ctl_t         ctl_i,
  input  logic [AW-1:0]              addr_i,
  input  logic [bfie_pkg::ByteW-1:0] wdata_i,
  output logic [bfie_pkg::ByteW-1:0] rdata_o,
  output logic                       busy_o
);
  import bfie_pkg::*;

  logic [ByteW-1:0] mem [DEPTH];
  logic [ByteW-1:0] rdata_q;
  logic             clr_busy_q, clr_busy_d;
  logic [AW-1:0]    clr_cnt_q, clr_cnt_d;

  // zeroing sweep after reset, one cell a cycle
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (ctl_i.we) begin
      mem[addr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_busy_q;
endmodule

// File: rtl/bfie_checker.sv
`include "brainfuck_instruction_executor_core_assert.svh"

module bfie_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        ov_i,
  input logic [7:0]  ob_i,
  input logic        ti_i,
  input logic        halted_i,
  input logic [1:0]  reason_i,
  input logic [12:0] pc_i
);
  // one item at a time: no accept right after an accept
  `BFIE_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "item accepted while another is in flight")

  // halted and reason agree
  `BFIE_ASSERT_IMP(a_halt_reason, clk_i, rst_ni, out_valid_i, halted_i == (reason_i != 2'd0), "halted and halt_reason disagree")

  // an output byte only from a running machine, never with input, else zero
  `BFIE_ASSERT_IMP(a_out_byte, clk_i, rst_ni, out_valid_i, (ov_i ? (!ti_i && !halted_i) : (ob_i == 8'd0)), "output byte fields inconsistent")

  // a stalled result holds
  `BFIE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(pc_i) && $stable(reason_i), "stalled result changed")
endmodule

bind brainfuck_instruction_executor_core bfie_checker u_bfie_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .ov_i        (out_ch.out_valid),
  .ob_i        (out_ch.out_byte),
  .ti_i        (out_ch.took_input),
  .halted_i    (out_ch.halted),
  .reason_i    (out_ch.halt_reason),
  .pc_i        (out_ch.pc_value)
);

// File: tb/brainfuck_instruction_executor_core_tb.sv
`timescale 1ns / 1ps

module brainfuck_instruction_executor_core_tb;
  import bfie_pkg::*;

  // mode value outside the three defined operations, must act as a no-op
  localparam logic [ModeW-1:0] ModeSpare = 2'd3;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned StallStretch = 400;
  localparam int unsigned MaxReports = 10;

  localparam logic [ByteW-1:0] CmdChars [8] = '{
    OpRight, OpLeft, OpOut, OpIn, OpInc, OpDec, OpJmpF, OpJmpB
  };

  // directed program: forward jump over "[-]", then "+>,.-<" and a "]" whose
  // backward scan finds no opening bracket
  localparam logic [ByteW-1:0] DirectedProg [10] = '{
    OpJmpF, OpDec, OpJmpB, OpInc, OpRight, OpIn, OpOut, OpDec, OpLeft, OpJmpB
  };

  typedef struct packed {
    logic              out_valid;
    logic [ByteW-1:0]  out_byte;
    logic              took_input;
    logic              halted;
    reason_e           halt_reason;
    logic [PcOutW-1:0] pc_value;
  } step_report_t;

  // shadow copy of the machine plus the queue of reports still owed by the block
  class tape_machine_sb;
    logic [ByteW-1:0] program_mem [CodeDepthDef];
    bit               program_set [CodeDepthDef];
    logic [ByteW-1:0] tape [DataDepthDef];
    int unsigned      pc;
    int unsigned      head;
    logic [FlagW-1:0] halt_bits;
    int unsigned      code_len;
    int unsigned      cell_limit;
    step_report_t     reports_due [$];
    int unsigned      mismatches;
    int unsigned      checked;

    function new();
      foreach (tape[i]) tape[i] = '0;
      foreach (program_mem[i]) program_mem[i] = '0;
      pc = 0;
      head = 0;
      halt_bits = '0;
      code_len = CodeLenRst;
      cell_limit = MemLimRst;
      mismatches = 0;
      checked = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
      if (idx == CfgCodeLen) begin
        code_len = val[CodeLenW-1:0];
      end else begin
        cell_limit = val[MemLimW-1:0];
      end
    endfunction

    function int unsigned eff_len();
      return (code_len > CodeDepthDef) ? CodeDepthDef : code_len;
    endfunction

    function int unsigned eff_lim();
      int unsigned m;
      m = (cell_limit > DataDepthDef) ? DataDepthDef : cell_limit;
      return (m == 0) ? 1 : m;
    endfunction

    // walk from pc to the matching bracket; returns 1 when the walk runs off the code
    // an unloaded code byte on the way is reported through missing
    function bit find_match(bit fwd, int unsigned len, output int unsigned stop,
                            output int missing);
      int unsigned p;
      int unsigned depth;
      logic [ByteW-1:0] same;
      logic [ByteW-1:0] other;
      p = pc;
      depth = 1;
      same = fwd ? OpJmpF : OpJmpB;
      other = fwd ? OpJmpB : OpJmpF;
      missing = -1;
      while (depth > 0) begin
        if (fwd ? (p + 1 >= len) : (p == 0)) begin
          stop = p;
          return 1'b1;
        end
        p = fwd ? p + 1 : p - 1;
        if (!program_set[p]) begin
          missing = p;
          stop = p;
          return 1'b0;
        end
        if (program_mem[p] == same) depth++;
        else if (program_mem[p] == other) depth--;
      end
      stop = p;
      return 1'b0;
    endfunction

    // first never-loaded code address the next step would read, or -1
    function int missing_read();
      int unsigned len;
      int unsigned stop;
      int miss;
      len = eff_len();
      if (halt_bits != '0 || pc >= len) return -1;
      if (!program_set[pc]) return pc;
      miss = -1;
      if (program_mem[pc] == OpJmpF && tape[head] == '0) begin
        void'(find_match(1'b1, len, stop, miss));
      end else if (program_mem[pc] == OpJmpB && tape[head] != '0) begin
        void'(find_match(1'b0, len, stop, miss));
      end
      return miss;
    endfunction

    function void execute_op(logic [ByteW-1:0] inb, inout step_report_t r);
      int unsigned len;
      int unsigned stop;
      int miss;
      bit ran_off;
      logic [ByteW-1:0] op;
      len = eff_len();
      if (pc >= len) halt_bits[FlagEnd] = 1'b1;
      if (halt_bits != '0) return;
      op = program_mem[pc];
      ran_off = 1'b0;
      case (op)
        OpRight: begin
          if (head + 1 >= eff_lim()) halt_bits[FlagPtr] = 1'b1;
          else head++;
        end
        OpLeft: begin
          if (head == 0) halt_bits[FlagPtr] = 1'b1;
          else head--;
        end
        OpOut: begin
          r.out_valid = 1'b1;
          r.out_byte = tape[head];
        end
        OpIn: begin
          tape[head] = inb;
          r.took_input = 1'b1;
        end
        OpInc: tape[head] = tape[head] + 8'd1;
        OpDec: tape[head] = tape[head] - 8'd1;
        OpJmpF: begin
          if (tape[head] == '0) begin
            ran_off = find_match(1'b1, len, stop, miss);
            pc = stop;
          end
        end
        OpJmpB: begin
          if (tape[head] != '0) begin
            ran_off = find_match(1'b0, len, stop, miss);
            pc = stop;
          end
        end
        default: ;
      endcase
      if (ran_off) halt_bits[FlagBrk] = 1'b1;
      else pc++;
    endfunction

    function void note_item(logic [ModeW-1:0] mode, logic [CodeAddrW-1:0] addr,
                            logic [ByteW-1:0] cbyte, logic [ByteW-1:0] inb);
      step_report_t r;
      r = '0;
      case (mode)
        ModeLoad: begin
          program_mem[addr] = cbyte;
          program_set[addr] = 1'b1;
        end
        ModeRestart: begin
          pc = 0;
          head = 0;
          halt_bits = '0;
        end
        ModeStep: execute_op(inb, r);
        default: ;
      endcase
      r.halted = (halt_bits != '0);
      if (halt_bits[FlagBrk]) r.halt_reason = ReasonBrk;
      else if (halt_bits[FlagPtr]) r.halt_reason = ReasonPtr;
      else if (halt_bits[FlagEnd]) r.halt_reason = ReasonEnd;
      else r.halt_reason = ReasonRun;
      r.pc_value = pc[PcOutW-1:0];
      reports_due.push_back(r);
    endfunction

    function void check_result(step_report_t got);
      step_report_t want;
      checked++;
      if (reports_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("%0t: result with nothing outstanding: pc=%0d", $realtime, got.pc_value);
        end
        return;
      end
      want = reports_due.pop_front();
      if (got.out_valid !== want.out_valid || got.out_byte !== want.out_byte ||
          got.took_input !== want.took_input || got.halted !== want.halted ||
          got.halt_reason !== want.halt_reason || got.pc_value !== want.pc_value) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("%0t: mismatch exp ov=%0d ob=%02h ti=%0d h=%0d why=%0d pc=%0d",
                   $realtime, want.out_valid, want.out_byte, want.took_input,
                   want.halted, want.halt_reason, want.pc_value);
          $display("%0t:          got ov=%0d ob=%02h ti=%0d h=%0d why=%0d pc=%0d",
                   $realtime, got.out_valid, got.out_byte, got.took_input,
                   got.halted, got.halt_reason, got.pc_value);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  bfie_in_if  in_ch ();
  bfie_out_if out_ch ();

  tape_machine_sb sb;
  int unsigned sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count = 0;
  bit stalled_once = 1'b0;

  brainfuck_instruction_executor_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random back-pressure, plus one long hold-off so the block
  // fills up and has to stall its input while the sender keeps offering items
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!stalled_once && sb.checked >= 1000) begin
        stalled_once = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (StallStretch) @(posedge clk_i);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // every accepted result goes straight to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      sb.check_result('{out_valid: out_ch.out_valid, out_byte: out_ch.out_byte,
                        took_input: out_ch.took_input, halted: out_ch.halted,
                        halt_reason: reason_e'(out_ch.halt_reason),
                        pc_value: out_ch.pc_value});
    end
  end

  // offer one item, with random gaps in front; returns at the accepting edge
  task automatic send_item(logic [ModeW-1:0] mode, logic [CodeAddrW-1:0] addr,
                           logic [ByteW-1:0] cbyte, logic [ByteW-1:0] inb);
    // idle pattern: sender light / receiver heavy, then swapped, then none
    if (sent < 650) begin
      send_idle_pct = 15;
      recv_idle_pct = 80;
    end else if (sent < 1300) begin
      send_idle_pct = 80;
      recv_idle_pct = 15;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= mode;
    in_ch.code_addr <= addr;
    in_ch.code_byte <= cbyte;
    in_ch.in_byte   <= inb;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_item(mode, addr, cbyte, inb);
    sent++;
  endtask

  // registers change only with nothing in flight; both written back to back
  task automatic set_machine_config(logic [CfgDataW-1:0] len_val,
                                    logic [CfgDataW-1:0] lim_val);
    in_ch.valid <= 1'b0;
    while (sb.reports_due.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgCodeLen;
    cfg_wdata_i <= len_val;
    @(posedge clk_i);
    cfg_idx_i   <= CfgMemLimit;
    cfg_wdata_i <= lim_val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(CfgCodeLen, len_val);
    sb.write_reg(CfgMemLimit, lim_val);
  endtask

  function automatic logic [ByteW-1:0] prog_char();
    if ($urandom_range(99) < 85) return CmdChars[$urandom_range(7)];
    return $urandom_range(255);
  endfunction

  // load a short program from address 0 and restart; most have balanced
  // brackets, a few are left broken on purpose
  task automatic new_program();
    int unsigned n;
    int unsigned depth;
    bit broken;
    logic [ByteW-1:0] c;
    n = $urandom_range(4, 24);
    if (sb.eff_len() != 0 && n > sb.eff_len()) n = sb.eff_len();
    broken = ($urandom_range(9) == 0);
    depth = 0;
    for (int i = 0; i < n; i++) begin
      c = prog_char();
      if (!broken && depth > 0 && n - i <= depth) c = OpJmpB;
      else if (!broken && c == OpJmpF && n - i - 1 <= depth) c = OpInc;
      else if (!broken && c == OpJmpB && depth == 0) c = OpDec;
      if (c == OpJmpF) depth++;
      else if (c == OpJmpB && depth > 0) depth--;
      send_item(ModeLoad, i, c, $urandom_range(255));
    end
    send_item(ModeRestart, $urandom_range(4095), $urandom_range(255), $urandom_range(255));
  endtask

  task automatic random_item();
    int unsigned pick;
    int miss;
    logic [ByteW-1:0] inb;
    pick = $urandom_range(99);
    inb = ($urandom_range(9) < 3) ? 8'd0 : 8'($urandom_range(255));
    if (sb.halt_bits != '0 && pick < 50) begin
      send_item(ModeRestart, $urandom_range(4095), $urandom_range(255), inb);
    end else if (pick < 78) begin
      // never let a step read code that was not loaded: load it first
      miss = sb.missing_read();
      if (miss >= 0) begin
        send_item(ModeLoad, miss, prog_char(), inb);
      end else begin
        send_item(ModeStep, $urandom_range(4095), $urandom_range(255), inb);
      end
    end else if (pick < 84) begin
      send_item(ModeRestart, $urandom_range(4095), $urandom_range(255), inb);
    end else if (pick < 92) begin
      // stray load, near the program or anywhere in the store
      send_item(ModeLoad, $urandom_range(1) ? $urandom_range(63) : $urandom_range(4095),
                prog_char(), inb);
    end else if (pick < 95) begin
      send_item(ModeSpare, $urandom_range(4095), $urandom_range(255), inb);
    end else begin
      new_program();
    end
  endtask

  initial begin
    logic [CfgDataW-1:0] len_val;
    logic [CfgDataW-1:0] lim_val;
    sb = new();
    rst_ni          <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= ModeLoad;
    in_ch.code_addr <= '0;
    in_ch.code_byte <= '0;
    in_ch.in_byte   <= '0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= CfgCodeLen;
    cfg_wdata_i     <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset config: length 1, so one '+' then the end-of-code halt
    // the block is clearing its data store first, the handshake waits for it
    send_item(ModeSpare, 12'hFFF, 8'hFF, 8'hFF);
    send_item(ModeLoad, 0, OpInc, 8'h00);
    send_item(ModeStep, 0, 8'h00, 8'h00);
    send_item(ModeStep, 0, 8'h00, 8'h00);

    // every command, both scans, and a bracket with no partner
    set_machine_config(10, 2);
    for (int i = 0; i < 10; i++) send_item(ModeLoad, i, DirectedProg[i], 8'h00);
    send_item(ModeLoad, 12'hFFF, 8'hFF, 8'h00);
    send_item(ModeRestart, 0, 8'h00, 8'h00);
    for (int i = 0; i < 9; i++) send_item(ModeStep, 0, 8'h00, 8'hFF);

    // random phases, each under its own register setting
    for (int p = 0; p < 12; p++) begin
      case (p)
        0: begin
          len_val = $urandom_range(8, 32);
          lim_val = 30000;
        end
        1: begin
          len_val = 0;
          lim_val = 1;
        end
        2: begin
          len_val = $urandom_range(4, 24);
          lim_val = 0;
        end
        3: begin
          len_val = 16'hFFFF;
          lim_val = 16'hFFFF;
        end
        4: begin
          len_val = 4096;
          lim_val = 32768;
        end
        5: begin
          len_val = 1;
          lim_val = 2;
        end
        default: begin
          len_val = $urandom_range(2, 48);
          case ($urandom_range(3))
            0: lim_val = $urandom_range(1, 4);
            1: lim_val = $urandom_range(5, 400);
            2: lim_val = 30000;
            default: lim_val = $urandom_range(30001, 65535);
          endcase
        end
      endcase
      set_machine_config(len_val, lim_val);
      new_program();
      for (int k = 0; k < 90; k++) random_item();
    end

    // drain, then give the block time to show any extra result
    in_ch.valid <= 1'b0;
    while (sb.reports_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.reports_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/bfie_pkg.sv
rtl/bfie_if.sv
rtl/bfie_code_mem.sv
rtl/bfie_data_mem.sv
rtl/brainfuck_instruction_executor_core.sv
rtl/bfie_checker.sv
tb/brainfuck_instruction_executor_core_tb.sv
